@@ src/cdtss_pkg.sv @@
// Shared constants and the segment decoder for the countdown timer block.
// No dependencies; imported by countdown_timer_seven_segment and its testbench.
package cdtss_pkg;

  // Default number of display digits.
  localparam int DIGIT_COUNT_DEF = 4;

  // Run mode codes, as reported on the result channel.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_ALARM = 2'd2;

  // Register reset values.
  localparam logic [7:0] FRAMES_PER_UNIT_RST = 8'd45;
  localparam logic [7:0] ALARM_FRAMES_RST    = 8'd26;

  // Register indexes on the configuration port.
  localparam logic REG_FRAMES_PER_UNIT = 1'b0;
  localparam logic REG_ALARM_FRAMES    = 1'b1;

  // Segment pattern g..a for one BCD digit; a non-decimal code shows blank.
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

@@ src/countdown_timer_seven_segment.sv @@
// Countdown timer with a multiplexed seven-segment display: scan, BCD value,
// run modes and an APB-style register port. Depends on cdtss_pkg.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  up_pressed, down_pressed, start_pressed
//  out_     output     out_valid / out_stall segments, digit_enable, buzzer, run_mode
//  cfg_     input      psel/penable/pready  paddr, pwdata, prdata (two 8-bit registers)
//
// A beat's result is formed from the state in the same cycle that the beat is
// accepted and appears in the output register on the next cycle, so a beat can
// be taken on every clock while the input is not stalled.
// rst_n is synchronous and active low; it clears the time value, mode, frame
// count, scan slot and output valid and presets the registers. The input is stalled
// only while the output register holds a result that the receiver is stalling.
module countdown_timer_seven_segment #(
  parameter int DIGIT_COUNT = cdtss_pkg::DIGIT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_up_pressed,
  input  logic        in_down_pressed,
  input  logic        in_start_pressed,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_segments,
  output logic [3:0]  out_digit_enable,
  output logic        out_buzzer,
  output logic [1:0]  out_run_mode,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cdtss_pkg::*;

  localparam int SW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(DIGIT_COUNT - 1);

  // State.
  logic [3:0]    digits_r [DIGIT_COUNT];
  logic [3:0]    digits_nxt [DIGIT_COUNT];
  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    frame_cnt_r, frame_cnt_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [7:0]    fpu_r, alarm_r;

  // Output register.
  logic       out_valid_r;
  logic [6:0] out_segments_r;
  logic [3:0] out_digit_enable_r;
  logic       out_buzzer_r;
  logic [1:0] out_run_mode_r;

  logic accept;
  logic cfg_wr;

  // Combinational working values.
  logic [3:0] inc_v [DIGIT_COUNT];
  logic [3:0] up_v  [DIGIT_COUNT];
  logic [3:0] dn_v  [DIGIT_COUNT];
  logic [3:0] cdn_v [DIGIT_COUNT];
  logic       cur_zero, cur_max, up_zero, dn_zero, cdn_zero;
  logic [1:0] mode_eff;
  logic [8:0] cnt_inc, fpu_lim, alarm_lim;
  logic [6:0] seg_now;
  logic [3:0] en_now;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Register port: always ready, decoded on the word address bit.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ALARM_FRAMES) ? {24'd0, alarm_r} : {24'd0, fpu_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpu_r   <= FRAMES_PER_UNIT_RST;
      alarm_r <= ALARM_FRAMES_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAMES_PER_UNIT) begin
        fpu_r <= pwdata[7:0];
      end else begin
        alarm_r <= pwdata[7:0];
      end
    end
  end

  // BCD increment and decrement chains for the frame-end updates.
  always_comb begin
    logic carry, borrow, cborrow;
    cur_max  = 1'b1;
    cur_zero = 1'b1;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (digits_r[i] != 4'd9) cur_max = 1'b0;
      if (digits_r[i] != 4'd0) cur_zero = 1'b0;
    end
    // Saturating increment.
    carry = !cur_max;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      inc_v[i] = digits_r[i];
      if (carry) begin
        if (digits_r[i] >= 4'd9) begin
          inc_v[i] = 4'd0;
        end else begin
          inc_v[i] = 4'(digits_r[i] + 4'd1);
          carry = 1'b0;
        end
      end
    end
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      up_v[i] = in_up_pressed ? inc_v[i] : digits_r[i];
    end
    up_zero = 1'b1;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (up_v[i] != 4'd0) up_zero = 1'b0;
    end
    // Saturating decrement after the button increment (idle).
    borrow = in_down_pressed && !up_zero;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      dn_v[i] = up_v[i];
      if (borrow) begin
        if (up_v[i] == 4'd0) begin
          dn_v[i] = 4'd9;
        end else begin
          dn_v[i] = 4'(up_v[i] - 4'd1);
          borrow = 1'b0;
        end
      end
    end
    // Countdown decrement of the current value.
    cborrow = !cur_zero;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      cdn_v[i] = digits_r[i];
      if (cborrow) begin
        if (digits_r[i] == 4'd0) begin
          cdn_v[i] = 4'd9;
        end else begin
          cdn_v[i] = 4'(digits_r[i] - 4'd1);
          cborrow = 1'b0;
        end
      end
    end
    dn_zero  = 1'b1;
    cdn_zero = 1'b1;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (dn_v[i] != 4'd0) dn_zero = 1'b0;
      if (cdn_v[i] != 4'd0) cdn_zero = 1'b0;
    end
  end

  // Result of the current slot, taken from the state before the update.
  always_comb begin
    case (mode_r)
      MODE_COUNT: mode_eff = MODE_COUNT;
      MODE_ALARM: mode_eff = MODE_ALARM;
      default:    mode_eff = MODE_IDLE;
    endcase
    seg_now = seg_of(digits_r[slot_r]);
    for (int k = 0; k < 4; k++) begin
      en_now[k] = (32'(slot_r) == k);
    end
  end

  // Next state: the scan slot advances every beat, frame work at the last slot.
  always_comb begin
    cnt_inc   = {1'b0, frame_cnt_r} + 9'd1;
    fpu_lim   = (fpu_r == 8'd0) ? 9'd1 : {1'b0, fpu_r};
    alarm_lim = (alarm_r == 8'd0) ? 9'd1 : {1'b0, alarm_r};
    digits_nxt    = digits_r;
    frame_cnt_nxt = frame_cnt_r;
    mode_nxt      = mode_eff;
    slot_nxt      = SW'(slot_r + 1'b1);
    if (slot_r == LAST_SLOT) begin
      slot_nxt = '0;
      case (mode_eff)
        MODE_COUNT: begin
          if (cnt_inc >= fpu_lim) begin
            frame_cnt_nxt = 8'd0;
            digits_nxt    = cdn_v;
            if (cdn_zero) mode_nxt = MODE_ALARM;
          end else begin
            frame_cnt_nxt = cnt_inc[7:0];
          end
        end
        MODE_ALARM: begin
          if (cnt_inc >= alarm_lim) begin
            frame_cnt_nxt = 8'd0;
            mode_nxt      = MODE_IDLE;
          end else begin
            frame_cnt_nxt = cnt_inc[7:0];
          end
        end
        default: begin
          digits_nxt = dn_v;
          if (in_start_pressed) begin
            frame_cnt_nxt = 8'd0;
            mode_nxt      = dn_zero ? MODE_ALARM : MODE_COUNT;
          end
        end
      endcase
    end
  end

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) digits_r[i] <= 4'd0;
      mode_r      <= MODE_IDLE;
      frame_cnt_r <= 8'd0;
      slot_r      <= '0;
    end else if (accept) begin
      digits_r    <= digits_nxt;
      mode_r      <= mode_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      slot_r      <= slot_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_segments_r     <= seg_now;
      out_digit_enable_r <= en_now;
      out_buzzer_r       <= (mode_eff == MODE_ALARM);
      out_run_mode_r     <= mode_eff;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segments     = out_segments_r;
  assign out_digit_enable = out_digit_enable_r;
  assign out_buzzer       = out_buzzer_r;
  assign out_run_mode     = out_run_mode_r;

  // The value is never zero while counting down.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_COUNT) |-> !cur_zero)
    else $error("counting with a zero value");

  // The frame counter is cleared whenever the block sits idle.
  a_idle_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (frame_cnt_r == 8'd0))
    else $error("frame count not clear in idle");

  // The scan slot steps by one on an accepted beat that does not end a frame.
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && slot_r != LAST_SLOT) |=> (32'(slot_r) == 32'($past(slot_r)) + 1))
    else $error("scan slot did not advance");

  // A stalled result is neither dropped nor replaced.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_segments_r)
      && $stable(out_digit_enable_r)))
    else $error("stalled result lost");

endmodule

@@ tb/sv/countdown_timer_seven_segment_tb.sv @@
// Self-checking testbench for the countdown timer with a seven-segment scan.
// Depends on cdtss_pkg and countdown_timer_seven_segment; predicts every result beat.
`timescale 1ns / 1ps

module countdown_timer_seven_segment_tb;
  import cdtss_pkg::*;

  // One result beat: the digit shown in a scan slot plus the status outputs.
  typedef struct packed {
    logic [6:0] segments;
    logic [3:0] digit_enable;
    logic       buzzer;
    logic [1:0] run_mode;
  } disp_beat_t;

  // Segment patterns g..a for the decimal digits.
  localparam logic [6:0] SEG_LUT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_up_pressed = 1'b0;
  logic        in_down_pressed = 1'b0;
  logic        in_start_pressed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_segments;
  logic [3:0]  out_digit_enable;
  logic        out_buzzer;
  logic [1:0]  out_run_mode;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the timer and its registers.
  logic [3:0]  tmr_digit [4];
  logic [1:0]  run_md;
  logic [7:0]  frame_cnt;
  logic [1:0]  scan_pos;
  logic [7:0]  unit_frames;
  logic [7:0]  buzz_frames;

  disp_beat_t  expected_disp_q [$];
  int          err_cnt = 0;
  int          beats_sent = 0;
  bit          bubbles_on = 1'b1;
  int          stall_left = 0;

  countdown_timer_seven_segment DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_up_pressed    (in_up_pressed),
    .in_down_pressed  (in_down_pressed),
    .in_start_pressed (in_start_pressed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_segments     (out_segments),
    .out_digit_enable (out_digit_enable),
    .out_buzzer       (out_buzzer),
    .out_run_mode     (out_run_mode),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // Helpers on the predicted BCD value; digit 0 is the most significant.
  function automatic bit value_zero();
    bit z;
    z = 1'b1;
    for (int i = 0; i < 4; i++) if (tmr_digit[i] != 4'd0) z = 1'b0;
    return z;
  endfunction

  function automatic bit value_max();
    bit m;
    m = 1'b1;
    for (int i = 0; i < 4; i++) if (tmr_digit[i] != 4'd9) m = 1'b0;
    return m;
  endfunction

  function automatic void value_up();
    bit carry;
    carry = 1'b1;
    if (value_max()) return;
    for (int i = 3; i >= 0; i--) begin
      if (carry) begin
        if (tmr_digit[i] == 4'd9) begin
          tmr_digit[i] = 4'd0;
        end else begin
          tmr_digit[i] = tmr_digit[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  endfunction

  function automatic void value_down();
    bit borrow;
    borrow = 1'b1;
    if (value_zero()) return;
    for (int i = 3; i >= 0; i--) begin
      if (borrow) begin
        if (tmr_digit[i] == 4'd0) begin
          tmr_digit[i] = 4'd9;
        end else begin
          tmr_digit[i] = tmr_digit[i] - 4'd1;
          borrow = 1'b0;
        end
      end
    end
  endfunction

  // Forms the beat shown in the current slot, then applies the frame-end actions.
  function automatic disp_beat_t step_display(input bit up, input bit dn, input bit st);
    disp_beat_t r;
    int unsigned lim;
    r.segments     = SEG_LUT[tmr_digit[scan_pos]];
    r.digit_enable = 4'b0001 << scan_pos;
    r.buzzer       = (run_md == MODE_ALARM);
    r.run_mode     = run_md;
    if (scan_pos == 2'd3) begin
      scan_pos = 2'd0;
      case (run_md)
        MODE_COUNT: begin
          lim = (unit_frames != 0) ? unit_frames : 1;
          if (int'(frame_cnt) + 1 >= lim) begin
            frame_cnt = 8'd0;
            value_down();
            if (value_zero()) run_md = MODE_ALARM;
          end else begin
            frame_cnt = frame_cnt + 8'd1;
          end
        end
        MODE_ALARM: begin
          lim = (buzz_frames != 0) ? buzz_frames : 1;
          if (int'(frame_cnt) + 1 >= lim) begin
            frame_cnt = 8'd0;
            run_md = MODE_IDLE;
          end else begin
            frame_cnt = frame_cnt + 8'd1;
          end
        end
        default: begin
          if (up) value_up();
          if (dn) value_down();
          if (st) begin
            frame_cnt = 8'd0;
            run_md = value_zero() ? MODE_ALARM : MODE_COUNT;
          end
        end
      endcase
    end else begin
      scan_pos = scan_pos + 2'd1;
    end
    return r;
  endfunction

  // Sends one input beat, with an optional gap first, and records its result.
  task automatic send_beat(input bit up, input bit dn, input bit st);
    if (bubbles_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_up_pressed    <= up;
    in_down_pressed  <= dn;
    in_start_pressed <= st;
    do @(posedge clk); while (in_stall);
    expected_disp_q.push_back(step_display(up, dn, st));
    beats_sent++;
  endtask

  // Sends beats up to the end of the current frame; buttons count only there.
  task automatic send_frame(input bit up, input bit dn, input bit st);
    bit last;
    do begin
      last = (scan_pos == 2'd3);
      if (last) send_beat(up, dn, st);
      else send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
    end while (!last);
  endtask

  // Lets the countdown and the alarm run out; buttons are random and ignored.
  task automatic run_until_idle();
    while (run_md != MODE_IDLE)
      send_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
  endtask

  // Stops the input and waits until every expected beat has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_disp_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic reg_idx, input logic [7:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_FRAMES_PER_UNIT) unit_frames = val;
    else buzz_frames = val;
  endtask

  // Reset state and scan order: two frames of zeros with no buttons.
  task automatic test_reset_scan();
    repeat (8) send_beat(1'b0, 1'b0, 1'b0);
  endtask

  // Down at zero saturates; up and down together at zero give zero again; then up to 11 and down to 1.
  task automatic test_floor();
    send_frame(1'b0, 1'b1, 1'b0);
    send_frame(1'b0, 1'b1, 1'b0);
    send_frame(1'b1, 1'b1, 1'b0);
    repeat (11) send_frame(1'b1, 1'b0, 1'b0);
    send_frame(1'b0, 1'b1, 1'b0);
    repeat (9) send_frame(1'b0, 1'b1, 1'b0);
  endtask

  // Countdown of one unit and the alarm with the reset register values.
  task automatic test_default_count();
    send_frame(1'b0, 1'b0, 1'b1);
    run_until_idle();
  endtask

  // Carry into the tens digit on the way up, then count down at one frame a unit.
  task automatic test_fast_count();
    drain();
    cfg_write(REG_FRAMES_PER_UNIT, 8'd1);
    cfg_write(REG_ALARM_FRAMES, 8'd2);
    repeat (10) send_frame(1'b1, 1'b0, 1'b0);
    send_frame(1'b0, 1'b0, 1'b1);
    run_until_idle();
  endtask

  // Zero in either register acts as one; a start at zero goes straight to the alarm.
  task automatic test_zero_regs();
    drain();
    cfg_write(REG_FRAMES_PER_UNIT, 8'd0);
    cfg_write(REG_ALARM_FRAMES, 8'd0);
    send_frame(1'b1, 1'b0, 1'b0);
    send_frame(1'b0, 1'b0, 1'b1);
    run_until_idle();
    send_frame(1'b0, 1'b0, 1'b1);
    run_until_idle();
  endtask

  // Random setting sequences: a few button frames, a start or some stray beats, then the countdown.
  task automatic test_random_sequences(input int n_beats, input bit allow_cfg);
    int stop_at;
    int n_set;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if (allow_cfg && $urandom_range(0, 3) == 0) begin
        drain();
        cfg_write(REG_FRAMES_PER_UNIT, 8'($urandom_range(1, 3)));
        cfg_write(REG_ALARM_FRAMES, 8'($urandom_range(1, 3)));
      end
      n_set = $urandom_range(0, 5);
      repeat (n_set)
        send_frame($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) begin
        // Broken sequence: random beats with no aligned start.
        repeat ($urandom_range(1, 7))
          send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end else begin
        send_frame(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 1'b1);
      end
      run_until_idle();
    end
  endtask

  // Result sink: random stall bursts while bubbles are on.
  always @(posedge clk) begin
    if (!rst_n || !bubbles_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Compares each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    disp_beat_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_disp_q.size() == 0) begin
        $error("unexpected result beat: segments %0h", out_segments);
        err_cnt++;
      end else begin
        exp_b = expected_disp_q.pop_front();
        if (out_segments !== exp_b.segments) begin
          $error("segments: expected %0h, actual %0h", exp_b.segments, out_segments);
          err_cnt++;
        end
        if (out_digit_enable !== exp_b.digit_enable) begin
          $error("digit_enable: expected %0h, actual %0h", exp_b.digit_enable,
                 out_digit_enable);
          err_cnt++;
        end
        if (out_buzzer !== exp_b.buzzer) begin
          $error("buzzer: expected %0h, actual %0h", exp_b.buzzer, out_buzzer);
          err_cnt++;
        end
        if (out_run_mode !== exp_b.run_mode) begin
          $error("run_mode: expected %0h, actual %0h", exp_b.run_mode, out_run_mode);
          err_cnt++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    for (int i = 0; i < 4; i++) tmr_digit[i] = 4'd0;
    run_md      = MODE_IDLE;
    frame_cnt   = 8'd0;
    scan_pos    = 2'd0;
    unit_frames = FRAMES_PER_UNIT_RST;
    buzz_frames = ALARM_FRAMES_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_scan();
    test_floor();
    test_default_count();
    test_fast_count();
    test_zero_regs();
    test_random_sequences(80, 1'b1);

    // Last part of the run without any idling on either side.
    drain();
    bubbles_on = 1'b0;
    cfg_write(REG_FRAMES_PER_UNIT, 8'd2);
    cfg_write(REG_ALARM_FRAMES, 8'd2);
    test_random_sequences(30, 1'b0);

    drain();
    repeat (5) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
src/cdtss_pkg.sv
src/countdown_timer_seven_segment.sv
tb/sv/countdown_timer_seven_segment_tb.sv
